### design/ccmap_pkg.sv
// ccmap_pkg: shared types, codes and constants of the controller-to-parameter mapper
// no dependencies; used by ccmap_ctrl, ccmap_dpath and midi_cc_parameter_mapper_top

package ccmap_pkg;

   // table geometry: one slot per channel and controller pair
   localparam int CHANNEL_COUNT = 16;
   localparam int VALUE_BITS    = 16;
   localparam int CC_BITS       = 7;
   localparam int CHAN_BITS     = 4;
   localparam int SLOT_BITS     = CHAN_BITS + CC_BITS;
   localparam int SLOT_COUNT    = 1 << SLOT_BITS;
   localparam int COUNT_BITS    = 12;
   localparam int ADDR_BITS     = 32;
   localparam int PVAL_BITS     = 16;
   localparam int RANGE_BITS    = 2 * PVAL_BITS;
   localparam int PAY_BITS      = ADDR_BITS + RANGE_BITS;

   // stream payload widths; the data widths are padded to whole bytes
   localparam int REQ_DATA_BITS = 88;
   localparam int REQ_USER_BITS = 3;
   localparam int RSP_DATA_BITS = 64;
   localparam int RSP_USER_BITS = 2;

   // range values keep their low VALUE_BITS bits
   localparam logic [PVAL_BITS-1:0] VALUE_MASK =
      (VALUE_BITS >= PVAL_BITS) ? {PVAL_BITS{1'b1}} : PVAL_BITS'((1 << VALUE_BITS) - 1);

   // slot flag bits
   localparam int FLAG_VALID  = 0;
   localparam int FLAG_ENABLE = 1;

   // rounding scale: floor((2*v*d + 127) / 254) equals floor((v*d + 63) / 127),
   // the division done as a multiply by a rounded-up reciprocal of 127
   localparam logic [5:0]  ROUND_BIAS  = 6'd63;
   localparam int          RECIP_SHIFT = 31;
   localparam logic [24:0] RECIP_MULT  = 25'd16909321;

   typedef enum logic [2:0] {
      OP_EVENT        = 3'd0,
      OP_ADD          = 3'd1,
      OP_REMOVE       = 3'd2,
      OP_SET_ENABLE   = 3'd3,
      OP_LEARN_START  = 3'd4,
      OP_LEARN_CANCEL = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_NONE        = 2'd0,
      KIND_PARAM_WRITE = 2'd1,
      KIND_LEARNED     = 2'd2,
      KIND_UPDATED     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MULT,
      ST_SCALE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic exec;
      logic mult;
      logic scale;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
      logic scale_hit;
   } dp_status_type;

endpackage

### design/midi_cc_parameter_mapper_top.sv
// After reset the block sweeps its 2048-slot mapping table clear, one slot a cycle, and
// accepts no request until the sweep is done. A table or learn request is then handled as a
// synchronous slot read followed by a write-back; a controller event that hits an enabled
// mapping adds the reciprocal multiplier stage and the offset stage of the scaler (the span
// product is formed in the write-back cycle).
// The result register lets a new request be accepted while the previous result waits; the
// request then holds in its execute cycle until that result is taken.
//
// midi_cc_parameter_mapper_top: top level of the controller-to-parameter mapper
// depends on ccmap_pkg, ccmap_ctrl and ccmap_dpath

module midi_cc_parameter_mapper_top
   import ccmap_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // midi_channel, cc_number, cc_value, param_addr, range_min, range_max, enable_flag
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // opcode
   input  logic [REQ_USER_BITS-1:0] req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // out_addr, out_value, learn_on, entry_count
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // result_kind
   output logic [RSP_USER_BITS-1:0] rsp_tuser
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencing
   ccmap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // table and arithmetic
   ccmap_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### design/ccmap_ctrl.sv
// ccmap_ctrl: sequencing state machine of the controller-to-parameter mapper
// depends on ccmap_pkg; drives the datapath through ctrl_cmd_type

module ccmap_ctrl
   import ccmap_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) state_in = status.scale_hit ? ST_MULT : ST_IDLE;
         end
         ST_MULT: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd            = '0;
      req_tready     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_EXEC: begin
            cmd.exec = status.out_free;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### design/ccmap_dpath.sv
// ccmap_dpath: mapping table, learn state, scaling pipeline and result register
// depends on ccmap_pkg; commanded by ccmap_ctrl

module ccmap_dpath
   import ccmap_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic [REQ_USER_BITS-1:0] req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [RSP_USER_BITS-1:0] rsp_tuser
);

   // request fields
   logic [CHAN_BITS-1:0] req_chan;
   logic [CC_BITS-1:0]   req_cc;
   logic [SLOT_BITS-1:0] req_idx;

   assign req_chan = req_tdata[3:0];
   assign req_cc   = req_tdata[10:4];
   assign req_idx  = {req_chan, req_cc};

   // table memories
   logic [1:0]          flag_mem [SLOT_COUNT];
   logic [PAY_BITS-1:0] pay_mem  [SLOT_COUNT];
   logic [1:0]          flag_rd_ff;
   logic [PAY_BITS-1:0] pay_rd_ff;

   // latched request
   logic [2:0]           rq_op_ff;
   logic [CC_BITS-1:0]   rq_val_ff;
   logic [ADDR_BITS-1:0] rq_addr_ff;
   logic [PVAL_BITS-1:0] rq_min_ff;
   logic [PVAL_BITS-1:0] rq_max_ff;
   logic                 rq_en_ff;
   logic                 rq_key_ok_ff;
   logic [SLOT_BITS-1:0] rq_idx_ff;

   // control state
   logic [SLOT_BITS-1:0]  clr_idx_ff;
   logic                  learn_active_ff, learn_active_in;
   logic [ADDR_BITS-1:0]  learn_addr_ff, learn_addr_in;
   logic [RANGE_BITS-1:0] learn_range_ff, learn_range_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // scaling pipeline
   logic [ADDR_BITS-1:0] res_addr_ff;
   logic [PVAL_BITS-1:0] sc_lo_ff;
   logic                 sc_empty_ff;
   logic [22:0]          sc_prod_ff;
   logic [47:0]          sc_recip_ff;

   // result register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [RSP_USER_BITS-1:0] rsp_user_ff;

   // decode
   logic                  store, drop, set_en, learn_set, learn_clr, hit;
   kind_type              kind;
   logic [ADDR_BITS-1:0]  oaddr;
   logic [ADDR_BITS-1:0]  st_addr;
   logic [RANGE_BITS-1:0] st_range;
   logic                  st_en;
   logic                  slot_valid;

   // write port
   logic                 flag_we;
   logic [SLOT_BITS-1:0] flag_waddr;
   logic [1:0]           flag_wdata;
   logic                 pay_we;

   // scale arithmetic
   logic [PVAL_BITS-1:0] rd_lo, rd_hi, rd_diff;
   logic [22:0]          biased;
   logic [PVAL_BITS-1:0] quot;
   logic [PVAL_BITS-1:0] scaled;

   assign slot_valid = flag_rd_ff[FLAG_VALID];

   // operation decode on the slot read back
   always_comb begin
      store     = 1'b0;
      drop      = 1'b0;
      set_en    = 1'b0;
      learn_set = 1'b0;
      learn_clr = 1'b0;
      hit       = 1'b0;
      kind      = KIND_NONE;
      oaddr     = '0;
      st_addr   = rq_addr_ff;
      st_range  = {rq_max_ff, rq_min_ff};
      st_en     = rq_en_ff;
      case (rq_op_ff)
         OP_EVENT: begin
            if (rq_key_ok_ff) begin
               if (learn_active_ff) begin
                  store     = 1'b1;
                  st_addr   = learn_addr_ff;
                  st_range  = learn_range_ff;
                  st_en     = 1'b1;
                  learn_clr = 1'b1;
                  kind      = KIND_LEARNED;
                  oaddr     = learn_addr_ff;
               end else if (flag_rd_ff[FLAG_VALID] && flag_rd_ff[FLAG_ENABLE]) begin
                  hit   = 1'b1;
                  kind  = KIND_PARAM_WRITE;
                  oaddr = pay_rd_ff[ADDR_BITS-1:0];
               end
            end
         end
         OP_ADD: begin
            if (rq_key_ok_ff) begin
               store = 1'b1;
               kind  = KIND_UPDATED;
            end
         end
         OP_REMOVE: begin
            if (rq_key_ok_ff && slot_valid) begin
               drop = 1'b1;
               kind = KIND_UPDATED;
            end
         end
         OP_SET_ENABLE: begin
            if (rq_key_ok_ff && slot_valid) begin
               set_en = 1'b1;
               kind   = KIND_UPDATED;
            end
         end
         OP_LEARN_START: begin
            learn_set = 1'b1;
            kind      = KIND_UPDATED;
         end
         OP_LEARN_CANCEL: begin
            learn_clr = 1'b1;
            kind      = KIND_UPDATED;
         end
         default: begin
            kind = KIND_NONE;
         end
      endcase
   end

   // table write port, shared by the clearing pass and execution
   always_comb begin
      flag_waddr = rq_idx_ff;
      flag_wdata = 2'b00;
      flag_we    = 1'b0;
      pay_we     = cmd.exec && store;
      if (cmd.clear_step) begin
         flag_we    = 1'b1;
         flag_waddr = clr_idx_ff;
      end else if (cmd.exec) begin
         flag_we = store || drop || set_en;
         if (store) begin
            flag_wdata = {st_en, 1'b1};
         end else if (set_en) begin
            flag_wdata = {rq_en_ff, 1'b1};
         end
      end
   end

   // memories: write at one address, registered read on acceptance
   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
      if (pay_we) pay_mem[rq_idx_ff] <= {st_range, st_addr};
      if (cmd.accept) begin
         flag_rd_ff <= flag_mem[req_idx];
         pay_rd_ff  <= pay_mem[req_idx];
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rq_op_ff     <= req_tuser;
         rq_val_ff    <= req_tdata[17:11];
         rq_addr_ff   <= req_tdata[49:18];
         rq_min_ff    <= req_tdata[65:50] & VALUE_MASK;
         rq_max_ff    <= req_tdata[81:66] & VALUE_MASK;
         rq_en_ff     <= req_tdata[82];
         rq_key_ok_ff <= ({1'b0, req_chan} < (CHAN_BITS + 1)'(CHANNEL_COUNT));
         rq_idx_ff    <= req_idx;
      end
   end

   // next learn state and mapping count
   always_comb begin
      learn_active_in = learn_active_ff;
      learn_addr_in   = learn_addr_ff;
      learn_range_in  = learn_range_ff;
      count_in        = count_ff;
      if (learn_set) begin
         learn_active_in = 1'b1;
         learn_addr_in   = rq_addr_ff;
         learn_range_in  = {rq_max_ff, rq_min_ff};
      end else if (learn_clr) begin
         learn_active_in = 1'b0;
         learn_addr_in   = '0;
         learn_range_in  = '0;
      end
      if (store && !slot_valid) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (drop) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff      <= '0;
         learn_active_ff <= 1'b0;
         learn_addr_ff   <= '0;
         learn_range_ff  <= '0;
         count_ff        <= '0;
      end else begin
         if (cmd.clear_step) clr_idx_ff <= clr_idx_ff + SLOT_BITS'(1);
         if (cmd.exec) begin
            learn_active_ff <= learn_active_in;
            learn_addr_ff   <= learn_addr_in;
            learn_range_ff  <= learn_range_in;
            count_ff        <= count_in;
         end
      end
   end

   // scaling: span product, reciprocal product, then offset by the minimum
   assign rd_lo   = pay_rd_ff[ADDR_BITS +: PVAL_BITS];
   assign rd_hi   = pay_rd_ff[ADDR_BITS + PVAL_BITS +: PVAL_BITS];
   assign rd_diff = rd_hi - rd_lo;
   assign biased  = sc_prod_ff + 23'(ROUND_BIAS);
   assign quot    = sc_recip_ff[RECIP_SHIFT +: PVAL_BITS];
   // the quotient never exceeds the span, so the sum stays within the maximum
   assign scaled  = sc_empty_ff ? sc_lo_ff : quot + sc_lo_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_addr_ff <= oaddr;
         sc_lo_ff    <= rd_lo;
         sc_empty_ff <= (rd_hi <= rd_lo);
         sc_prod_ff  <= 23'(rq_val_ff) * 23'(rd_diff);
      end
      if (cmd.mult) begin
         sc_recip_ff <= 48'(biased) * 48'(RECIP_MULT);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.exec && !hit) || cmd.scale) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && !hit) begin
         rsp_user_ff <= kind;
         rsp_data_ff <= {3'b000, count_in, learn_active_in, {PVAL_BITS{1'b0}}, oaddr};
      end else if (cmd.scale) begin
         rsp_user_ff <= KIND_PARAM_WRITE;
         rsp_data_ff <= {3'b000, count_ff, learn_active_ff, scaled, res_addr_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // status
   assign status.clear_last = &clr_idx_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign status.scale_hit  = hit;

endmodule

### tb/tb.sv
// tb: self-checking bench for the controller-to-parameter mapper, streaming requests and results
// depends on ccmap_pkg and midi_cc_parameter_mapper_top; holds its own table model for prediction

module tb
   import ccmap_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // opcodes the block must ignore
   localparam logic [2:0] OP_RESERVED_6 = 3'd6;
   localparam logic [2:0] OP_RESERVED_7 = 3'd7;
   localparam int         REPORT_LIMIT  = 40;
   localparam int         KEY_POOL_SIZE = 12;

   typedef struct packed {
      logic [2:0]           opcode;
      logic [CHAN_BITS-1:0] ch;
      logic [CC_BITS-1:0]   cc;
      logic [6:0]           val;
      logic [ADDR_BITS-1:0] addr;
      logic [PVAL_BITS-1:0] lo;
      logic [PVAL_BITS-1:0] hi;
      logic                 en;
   } cc_request_type;

   typedef struct packed {
      kind_type              kind;
      logic [ADDR_BITS-1:0]  addr;
      logic [PVAL_BITS-1:0]  value;
      logic                  learn_on;
      logic [COUNT_BITS-1:0] count;
   } cc_response_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [REQ_USER_BITS-1:0] req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;

   // mirror of the mapping table and learn state
   logic [1:0]            slot_flags [SLOT_COUNT];
   logic [ADDR_BITS-1:0]  slot_addr  [SLOT_COUNT];
   logic [PVAL_BITS-1:0]  slot_lo    [SLOT_COUNT];
   logic [PVAL_BITS-1:0]  slot_hi    [SLOT_COUNT];
   logic                  learn_busy;
   logic [ADDR_BITS-1:0]  learn_target;
   logic [PVAL_BITS-1:0]  learn_lo;
   logic [PVAL_BITS-1:0]  learn_hi;
   logic [COUNT_BITS-1:0] mapping_total;

   cc_response_type pending_results [$];
   int           mismatch_count = 0;
   int           burst_left     = 0;
   bit           tx_gaps_on     = 1'b1;
   int           hold_off_cycles = 0;

   midi_cc_parameter_mapper_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // rounded scaling of a 0..127 controller value into [lo, hi]
   function automatic logic [PVAL_BITS-1:0] scaled_value(logic [6:0] v,
                                                          logic [PVAL_BITS-1:0] lo,
                                                          logic [PVAL_BITS-1:0] hi);
      logic [63:0] num;
      logic [63:0] res;
      if (hi <= lo) return lo;
      num = 64'd2 * 64'(v) * 64'(hi - lo) + 64'd127;
      res = num / 64'd254 + 64'(lo);
      if (res > 64'(hi)) res = 64'(hi);
      return res[PVAL_BITS-1:0];
   endfunction

   // write one slot, counting it when it was empty
   function automatic void store_mapping(logic [SLOT_BITS-1:0] slot, logic [ADDR_BITS-1:0] addr,
                                         logic [PVAL_BITS-1:0] lo, logic [PVAL_BITS-1:0] hi,
                                         logic en);
      if (!slot_flags[slot][FLAG_VALID]) mapping_total = mapping_total + COUNT_BITS'(1);
      slot_flags[slot] = {en, 1'b1};
      slot_addr[slot]  = addr;
      slot_lo[slot]    = lo;
      slot_hi[slot]    = hi;
   endfunction

   // update the mirrored table with one request and return the result it gives
   function automatic cc_response_type apply_request(cc_request_type rq);
      cc_response_type      r;
      logic [SLOT_BITS-1:0] slot;
      logic                 key_ok;
      r      = '0;
      r.kind = KIND_NONE;
      slot   = {rq.ch, rq.cc};
      key_ok = int'(rq.ch) < CHANNEL_COUNT;
      case (rq.opcode)
         OP_EVENT: begin
            if (key_ok && learn_busy) begin
               store_mapping(slot, learn_target, learn_lo, learn_hi, 1'b1);
               r.kind       = KIND_LEARNED;
               r.addr       = learn_target;
               learn_busy   = 1'b0;
               learn_target = '0;
               learn_lo     = '0;
               learn_hi     = '0;
            end else if (key_ok && slot_flags[slot] == 2'b11) begin
               r.kind  = KIND_PARAM_WRITE;
               r.addr  = slot_addr[slot];
               r.value = scaled_value(rq.val, slot_lo[slot], slot_hi[slot]);
            end
         end
         OP_ADD: begin
            if (key_ok) begin
               store_mapping(slot, rq.addr, rq.lo & VALUE_MASK, rq.hi & VALUE_MASK, rq.en);
               r.kind = KIND_UPDATED;
            end
         end
         OP_REMOVE: begin
            if (key_ok && slot_flags[slot][FLAG_VALID]) begin
               slot_flags[slot] = 2'b00;
               mapping_total    = mapping_total - COUNT_BITS'(1);
               r.kind           = KIND_UPDATED;
            end
         end
         OP_SET_ENABLE: begin
            if (key_ok && slot_flags[slot][FLAG_VALID]) begin
               slot_flags[slot] = {rq.en, 1'b1};
               r.kind           = KIND_UPDATED;
            end
         end
         OP_LEARN_START: begin
            learn_busy   = 1'b1;
            learn_target = rq.addr;
            learn_lo     = rq.lo & VALUE_MASK;
            learn_hi     = rq.hi & VALUE_MASK;
            r.kind       = KIND_UPDATED;
         end
         OP_LEARN_CANCEL: begin
            learn_busy   = 1'b0;
            learn_target = '0;
            learn_lo     = '0;
            learn_hi     = '0;
            r.kind       = KIND_UPDATED;
         end
         default: ;
      endcase
      r.learn_on = learn_busy;
      r.count    = mapping_total;
      return r;
   endfunction

   // offer one request, in bursts with random gaps, and record its result once taken
   task automatic send_request(cc_request_type rq);
      int gap;
      gap = 0;
      if (tx_gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.opcode;
      req_tdata  <= {5'b0, rq.en, rq.hi, rq.lo, rq.addr, rq.val, rq.cc, rq.ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(apply_request(rq));
   endtask

   function automatic cc_request_type make_request(logic [2:0] op, logic [SLOT_BITS-1:0] key,
                                                   logic [6:0] val, logic [ADDR_BITS-1:0] addr,
                                                   logic [PVAL_BITS-1:0] lo,
                                                   logic [PVAL_BITS-1:0] hi, logic en);
      cc_request_type rq;
      rq.opcode = op;
      rq.ch     = key[SLOT_BITS-1:CC_BITS];
      rq.cc     = key[CC_BITS-1:0];
      rq.val    = val;
      rq.addr   = addr;
      rq.lo     = lo;
      rq.hi     = hi;
      rq.en     = en;
      return rq;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
   endtask

   // result checker: compare each taken result with the oldest expectation
   always @(posedge clock) begin : result_check
      cc_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, kind", 32'd0, 32'(rsp_tuser));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser != want.kind)
               report_mismatch("kind", 32'(want.kind), 32'(rsp_tuser));
            if (rsp_tdata[31:0] != want.addr) report_mismatch("addr", want.addr, rsp_tdata[31:0]);
            if (rsp_tdata[47:32] != want.value)
               report_mismatch("value", 32'(want.value), 32'(rsp_tdata[47:32]));
            if (rsp_tdata[48] != want.learn_on)
               report_mismatch("learn_on", 32'(want.learn_on), 32'(rsp_tdata[48]));
            if (rsp_tdata[60:49] != want.count)
               report_mismatch("entry_count", 32'(want.count), 32'(rsp_tdata[60:49]));
         end
      end
   end

   // result side: switches between always ready, random stalls and a fixed pattern,
   // with an occasional long hold-off when a test asks for one
   always @(posedge clock) begin : result_sink
      int   mode;
      int   mode_left;
      logic [7:0] pattern;
      if (hold_off_cycles > 0) begin
         hold_off_cycles = hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left <= 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
            pattern   = 8'($urandom_range(1, 255));
         end
         mode_left = mode_left - 1;
         pattern   = {pattern[6:0], pattern[7]};
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= pattern[0];
         endcase
      end
   end

   // add, overwrite, enable, remove, empty ranges and the reserved opcodes
   task automatic test_table_ops();
      send_request(make_request(OP_ADD, 11'h000, 7'd0, 32'h0000_0000, 16'h0000, 16'hFFFF, 1'b1));
      send_request(make_request(OP_EVENT, 11'h000, 7'd127, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 1'b1));
      send_request(make_request(OP_EVENT, 11'h000, 7'd0, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_ADD, 11'h000, 7'd0, 32'hFFFF_FFFF, 16'h0001, 16'hFFFE, 1'b0));
      send_request(make_request(OP_EVENT, 11'h000, 7'd64, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_SET_ENABLE, 11'h000, 7'd0, 32'h0, 16'h0, 16'h0, 1'b1));
      send_request(make_request(OP_EVENT, 11'h000, 7'd64, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_SET_ENABLE, 11'h7FF, 7'd0, 32'h0, 16'h0, 16'h0, 1'b1));
      send_request(make_request(OP_REMOVE, 11'h7FF, 7'd0, 32'h0, 16'h0, 16'h0, 1'b0));
      // empty range: equal bounds, then min above max
      send_request(make_request(OP_ADD, 11'h7FF, 7'd0, 32'h1234_5678, 16'd1000, 16'd1000, 1'b1));
      send_request(make_request(OP_EVENT, 11'h7FF, 7'd99, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_ADD, 11'h7FF, 7'd0, 32'h8765_4321, 16'd500, 16'd100, 1'b1));
      send_request(make_request(OP_EVENT, 11'h7FF, 7'd127, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_REMOVE, 11'h000, 7'd0, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_EVENT, 11'h000, 7'd127, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_RESERVED_6, 11'h7FF, 7'd127, 32'hFFFF_FFFF, 16'hFFFF,
                                16'hFFFF, 1'b1));
      send_request(make_request(OP_RESERVED_7, 11'h7FF, 7'd127, 32'hFFFF_FFFF, 16'hFFFF,
                                16'hFFFF, 1'b1));
   endtask

   // cancel while idle, retarget while learning, capture over an existing slot
   task automatic test_learn();
      send_request(make_request(OP_LEARN_CANCEL, 11'h000, 7'd0, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_LEARN_START, 11'h000, 7'd0, 32'hAAAA_0001, 16'd10, 16'd20,
                                1'b0));
      send_request(make_request(OP_LEARN_START, 11'h000, 7'd0, 32'h5555_0002, 16'd0, 16'd127,
                                1'b0));
      send_request(make_request(OP_EVENT, 11'h7FF, 7'd3, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_EVENT, 11'h7FF, 7'd77, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_LEARN_START, 11'h000, 7'd0, 32'h0BAD_F00D, 16'd1, 16'd9,
                                1'b1));
      send_request(make_request(OP_LEARN_CANCEL, 11'h000, 7'd0, 32'h0, 16'h0, 16'h0, 1'b0));
      send_request(make_request(OP_EVENT, 11'h185, 7'd50, 32'h0, 16'h0, 16'h0, 1'b0));
   endtask

   // long result hold-off with requests offered back to back
   task automatic test_backpressure();
      int i;
      send_request(make_request(OP_ADD, 11'h2A5, 7'd0, 32'hC0DE_0000, 16'd0, 16'd40000, 1'b1));
      tx_gaps_on      = 1'b0;
      hold_off_cycles = 300;
      for (i = 0; i < 30; i++)
         send_request(make_request(OP_EVENT, 11'h2A5, 7'($urandom_range(0, 127)), 32'h0,
                                   16'h0, 16'h0, 1'b0));
      tx_gaps_on = 1'b1;
   endtask

   // random traffic on a small key pool so events mostly hit live mappings
   task automatic test_random(int count);
      logic [SLOT_BITS-1:0] key_pool [KEY_POOL_SIZE];
      logic [SLOT_BITS-1:0] key;
      logic [PVAL_BITS-1:0] lo;
      logic [PVAL_BITS-1:0] hi;
      logic [6:0]           val;
      logic [2:0]           op;
      bit                   learn_next;
      int                   i;
      int                   pick;
      learn_next = 1'b0;
      for (i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = SLOT_BITS'($urandom_range(0, SLOT_COUNT-1));
      for (i = 0; i < count; i++) begin
         // pick the operation, favouring events and an event straight after learn start
         pick = $urandom_range(0, 99);
         if (learn_next && pick < 80) op = OP_EVENT;
         else if (pick < 45) op = OP_EVENT;
         else if (pick < 65) op = OP_ADD;
         else if (pick < 75) op = OP_REMOVE;
         else if (pick < 85) op = OP_SET_ENABLE;
         else if (pick < 92) op = OP_LEARN_START;
         else if (pick < 96) op = OP_LEARN_CANCEL;
         else if (pick < 98) op = OP_RESERVED_6;
         else op = OP_RESERVED_7;
         learn_next = (op == OP_LEARN_START);
         key = ($urandom_range(0, 9) == 0) ? SLOT_BITS'($urandom_range(0, SLOT_COUNT-1))
                                          : key_pool[$urandom_range(0, KEY_POOL_SIZE-1)];
         // ranges: mostly ordered, sometimes inverted or at the extremes
         lo = PVAL_BITS'($urandom_range(0, 65535));
         hi = PVAL_BITS'($urandom_range(0, 65535));
         case ($urandom_range(0, 5))
            0:       begin lo = 16'h0000; hi = 16'hFFFF; end
            1:       ;
            2:       hi = lo;
            default: if (hi < lo) {lo, hi} = {hi, lo};
         endcase
         case ($urandom_range(0, 4))
            0:       val = 7'd0;
            1:       val = 7'd127;
            default: val = 7'($urandom_range(0, 127));
         endcase
         send_request(make_request(op, key, val, $urandom, lo, hi,
                                   ($urandom_range(0, 3) != 0)));
      end
   endtask

   // run time limit
   initial begin
      #800_000;
      $display("simulation failed");
      $finish;
   end

   // test sequence
   initial begin
      foreach (slot_flags[i]) slot_flags[i] = 2'b00;
      learn_busy    = 1'b0;
      learn_target  = '0;
      learn_lo      = '0;
      learn_hi      = '0;
      mapping_total = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_ops();
      test_learn();
      test_backpressure();
      test_random(500);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
design/ccmap_pkg.sv
design/ccmap_ctrl.sv
design/ccmap_dpath.sv
design/midi_cc_parameter_mapper_top.sv
tb/tb.sv
